### src/owbm_pkg.sv
// shared types and constants for the one-wire bus master
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int TIMER_W    = 10;

    // request codes as they arrive on the request channel
    typedef enum logic [1:0] {
        REQ_RESET = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    // configuration register indexes (word address)
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_START   = 3'd3,
        REG_WRITE_HOLD    = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } reg_idx_t;

    // reset values of the timing registers
    localparam logic [9:0] RESET_LOW_INIT     = 10'd500;
    localparam logic [9:0] PRESENCE_WAIT_INIT = 10'd70;
    localparam logic [9:0] RESET_TAIL_INIT    = 10'd500;
    localparam logic [7:0] WRITE_START_INIT   = 8'd10;
    localparam logic [7:0] WRITE_HOLD_INIT    = 8'd50;
    localparam logic [7:0] READ_LOW_INIT      = 8'd5;
    localparam logic [7:0] READ_SAMPLE_INIT   = 8'd5;
    localparam logic [7:0] READ_TAIL_INIT     = 8'd50;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [7:0] write_start_us;
        logic [7:0] write_hold_us;
        logic [7:0] read_low_us;
        logic [7:0] read_sample_us;
        logic [7:0] read_tail_us;
    } timing_t;

    // one classified transaction waiting for the sequencer
    typedef struct packed {
        req_t       kind;
        logic [7:0] data_byte;
        logic       line_level;
    } q_entry_t;

    // handshake between queue and sequencer
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    // bus sequencer phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_RST_WAIT = 10'b00_0000_0100,
        PH_RST_TAIL = 10'b00_0000_1000,
        PH_WR_LOW   = 10'b00_0001_0000,
        PH_WR_HOLD  = 10'b00_0010_0000,
        PH_WR_REC   = 10'b00_0100_0000,
        PH_RD_LOW   = 10'b00_1000_0000,
        PH_RD_WAIT  = 10'b01_0000_0000,
        PH_RD_TAIL  = 10'b10_0000_0000
    } phase_t;

endpackage

### src/owbm_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface owbm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output req_type, output data_byte, output line_level,
                    input ready);
    modport sink (input valid, input req_type, input data_byte, input line_level,
                  output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       line_release;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, output line_release, output busy_res, output done_res,
                    output presence, output read_byte, output rejected, input ready);
    modport sink (input valid, input line_release, input busy_res, input done_res,
                  input presence, input read_byte, input rejected, output ready);
endinterface

### src/owbm_cfg.sv
// apb timing register file
`timescale 1ns / 1ps

module owbm_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [owbm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output owbm_pkg::timing_t                    timing
);

    owbm_pkg::timing_t  timing_reg;
    owbm_pkg::timing_t  timing_next;
    owbm_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = owbm_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign timing = timing_reg;

    always_comb
    begin
        timing_next = timing_reg;
        if (wr_en)
        begin
            unique case (idx)
                owbm_pkg::REG_RESET_LOW:     timing_next.reset_low_us     = pwdata[9:0];
                owbm_pkg::REG_PRESENCE_WAIT: timing_next.presence_wait_us = pwdata[9:0];
                owbm_pkg::REG_RESET_TAIL:    timing_next.reset_tail_us    = pwdata[9:0];
                owbm_pkg::REG_WRITE_START:   timing_next.write_start_us   = pwdata[7:0];
                owbm_pkg::REG_WRITE_HOLD:    timing_next.write_hold_us    = pwdata[7:0];
                owbm_pkg::REG_READ_LOW:      timing_next.read_low_us      = pwdata[7:0];
                owbm_pkg::REG_READ_SAMPLE:   timing_next.read_sample_us   = pwdata[7:0];
                owbm_pkg::REG_READ_TAIL:     timing_next.read_tail_us     = pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            owbm_pkg::REG_RESET_LOW:     prdata = {22'd0, timing_reg.reset_low_us};
            owbm_pkg::REG_PRESENCE_WAIT: prdata = {22'd0, timing_reg.presence_wait_us};
            owbm_pkg::REG_RESET_TAIL:    prdata = {22'd0, timing_reg.reset_tail_us};
            owbm_pkg::REG_WRITE_START:   prdata = {24'd0, timing_reg.write_start_us};
            owbm_pkg::REG_WRITE_HOLD:    prdata = {24'd0, timing_reg.write_hold_us};
            owbm_pkg::REG_READ_LOW:      prdata = {24'd0, timing_reg.read_low_us};
            owbm_pkg::REG_READ_SAMPLE:   prdata = {24'd0, timing_reg.read_sample_us};
            owbm_pkg::REG_READ_TAIL:     prdata = {24'd0, timing_reg.read_tail_us};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_us     <= owbm_pkg::RESET_LOW_INIT;
            timing_reg.presence_wait_us <= owbm_pkg::PRESENCE_WAIT_INIT;
            timing_reg.reset_tail_us    <= owbm_pkg::RESET_TAIL_INIT;
            timing_reg.write_start_us   <= owbm_pkg::WRITE_START_INIT;
            timing_reg.write_hold_us    <= owbm_pkg::WRITE_HOLD_INIT;
            timing_reg.read_low_us      <= owbm_pkg::READ_LOW_INIT;
            timing_reg.read_sample_us   <= owbm_pkg::READ_SAMPLE_INIT;
            timing_reg.read_tail_us     <= owbm_pkg::READ_TAIL_INIT;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

endmodule

### src/owbm_front.sv
// request intake: classifies transactions and queues them for the sequencer
`timescale 1ns / 1ps

module owbm_front
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    owbm_req_if.sink          req,
    input  logic              q_pop,
    output owbm_pkg::q_head_t q_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    owbm_pkg::q_entry_t q_mem [QUEUE_DEPTH];
    owbm_pkg::q_entry_t in_entry;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_entry.kind       = owbm_pkg::req_t'(req.req_type);
    assign in_entry.data_byte  = req.data_byte;
    assign in_entry.line_level = req.line_level;

    assign req.ready    = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign push         = req.valid && req.ready;
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.entry = q_mem[rd_ptr_reg];
    assign pop          = q_pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/owbm_back.sv
// bus sequencer: runs reset, write and read slots off the tick stream
`timescale 1ns / 1ps

module owbm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  owbm_pkg::timing_t timing,
    input  owbm_pkg::q_head_t q_head,
    output logic              q_pop,
    owbm_res_if.source        res
);

    owbm_pkg::phase_t phase_reg, phase_next;
    logic [9:0]       timer_reg, timer_next;
    logic [2:0]       bit_idx_reg, bit_idx_next;
    logic [7:0]       shift_reg, shift_next;
    logic             presence_reg, presence_next;
    logic             line_reg, line_next;
    logic [7:0]       last_read_reg, last_read_next;
    logic             done;
    logic             rej;

    logic             out_valid_reg;
    logic             out_line_reg;
    logic             out_busy_reg;
    logic             out_done_reg;
    logic             out_presence_reg;
    logic [7:0]       out_read_reg;
    logic             out_rej_reg;

    assign q_pop = q_head.valid && (!out_valid_reg || res.ready);

    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        line_next      = line_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rej            = 1'b0;

        if (q_head.entry.kind != owbm_pkg::REQ_TICK)
        begin
            if (phase_reg != owbm_pkg::PH_IDLE)
                rej = 1'b1;
            else
            begin
                unique case (q_head.entry.kind)
                    owbm_pkg::REQ_RESET:
                    begin
                        phase_next = owbm_pkg::PH_RST_LOW;
                        timer_next = timing.reset_low_us;
                        line_next  = 1'b0;
                    end
                    owbm_pkg::REQ_WRITE:
                    begin
                        shift_next   = q_head.entry.data_byte;
                        bit_idx_next = 3'd0;
                        phase_next   = owbm_pkg::PH_WR_LOW;
                        timer_next   = {2'd0, timing.write_start_us};
                        line_next    = 1'b0;
                    end
                    owbm_pkg::REQ_READ:
                    begin
                        shift_next   = 8'd0;
                        bit_idx_next = 3'd0;
                        phase_next   = owbm_pkg::PH_RD_LOW;
                        timer_next   = {2'd0, timing.read_low_us};
                        line_next    = 1'b0;
                    end
                    owbm_pkg::REQ_TICK: ;
                endcase
            end
        end
        else if (phase_reg != owbm_pkg::PH_IDLE)
        begin
            if (timer_reg > 10'd1)
                timer_next = timer_reg - 10'd1;
            else
            begin
                unique case (phase_reg)
                    owbm_pkg::PH_RST_LOW:
                    begin
                        phase_next = owbm_pkg::PH_RST_WAIT;
                        timer_next = timing.presence_wait_us;
                        line_next  = 1'b1;
                    end
                    owbm_pkg::PH_RST_WAIT:
                    begin
                        presence_next = ~q_head.entry.line_level;
                        phase_next    = owbm_pkg::PH_RST_TAIL;
                        timer_next    = timing.reset_tail_us;
                        line_next     = 1'b1;
                    end
                    owbm_pkg::PH_RST_TAIL:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        timer_next = 10'd0;
                        done       = 1'b1;
                    end
                    owbm_pkg::PH_WR_LOW:
                    begin
                        phase_next = owbm_pkg::PH_WR_HOLD;
                        timer_next = {2'd0, timing.write_hold_us};
                        line_next  = shift_reg[0];
                    end
                    owbm_pkg::PH_WR_HOLD:
                    begin
                        line_next  = 1'b1;
                        shift_next = {1'b0, shift_reg[7:1]};
                        if (bit_idx_reg == 3'd7)
                        begin
                            phase_next = owbm_pkg::PH_IDLE;
                            timer_next = 10'd0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            // one released recovery tick between bits
                            phase_next = owbm_pkg::PH_WR_REC;
                            timer_next = 10'd1;
                        end
                    end
                    owbm_pkg::PH_WR_REC:
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                        phase_next   = owbm_pkg::PH_WR_LOW;
                        timer_next   = {2'd0, timing.write_start_us};
                        line_next    = 1'b0;
                    end
                    owbm_pkg::PH_RD_LOW:
                    begin
                        phase_next = owbm_pkg::PH_RD_WAIT;
                        timer_next = {2'd0, timing.read_sample_us};
                        line_next  = 1'b1;
                    end
                    owbm_pkg::PH_RD_WAIT:
                    begin
                        shift_next = {q_head.entry.line_level, shift_reg[7:1]};
                        phase_next = owbm_pkg::PH_RD_TAIL;
                        timer_next = {2'd0, timing.read_tail_us};
                        line_next  = 1'b1;
                    end
                    owbm_pkg::PH_RD_TAIL:
                    begin
                        if (bit_idx_reg == 3'd7)
                        begin
                            last_read_next = shift_reg;
                            phase_next     = owbm_pkg::PH_IDLE;
                            timer_next     = 10'd0;
                            done           = 1'b1;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                            phase_next   = owbm_pkg::PH_RD_LOW;
                            timer_next   = {2'd0, timing.read_low_us};
                            line_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        timer_next = 10'd0;
                        line_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= owbm_pkg::PH_IDLE;
            timer_reg     <= 10'd0;
            bit_idx_reg   <= 3'd0;
            shift_reg     <= 8'd0;
            presence_reg  <= 1'b0;
            line_reg      <= 1'b1;
            last_read_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                bit_idx_reg   <= bit_idx_next;
                shift_reg     <= shift_next;
                presence_reg  <= presence_next;
                line_reg      <= line_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the post-transaction state
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_line_reg     <= line_next;
            out_busy_reg     <= (phase_next != owbm_pkg::PH_IDLE);
            out_done_reg     <= done;
            out_presence_reg <= presence_next;
            out_read_reg     <= last_read_next;
            out_rej_reg      <= rej;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.line_release = out_line_reg;
    assign res.busy_res     = out_busy_reg;
    assign res.done_res     = out_done_reg;
    assign res.presence     = out_presence_reg;
    assign res.read_byte    = out_read_reg;
    assign res.rejected     = out_rej_reg;

endmodule

### src/one_wire_bus_master.sv
// top level of the one-wire bus master
`timescale 1ns / 1ps

// One-wire bus master driven by a stream of transactions on the req channel: a
// transaction is a command (bus reset with presence detect, write byte, read byte) or
// a one-microsecond tick carrying the sampled bus level. Every accepted transaction
// yields exactly one result on the res channel with the line drive (1 released, 0 pulled
// low), busy, done, the last presence flag (1 when a device answered), the last byte read
// (lsb first) and a rejected flag for commands that arrive while an operation runs.
// Slot timing comes from eight apb registers at byte addresses 4*i (reset low, presence
// wait, reset tail, write start, write hold, read low, read sample, read tail); a value
// of zero behaves as one tick. The intake queue (QUEUE_DEPTH entries) decouples the
// request side from the sequencer, so a new transaction is taken while a result still
// waits on the output register. Throughput is one transaction per clock while res is
// ready; an accepted transaction is held in the queue register, then the output register,
// before its result shows on res. No clearing pass is needed after reset.
module one_wire_bus_master
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    owbm_req_if.sink                        req,
    owbm_res_if.source                      res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owbm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    owbm_pkg::timing_t timing;
    owbm_pkg::q_head_t q_head;
    logic              q_pop;

    // timing registers
    owbm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timing  (timing)
    );

    // intake queue
    owbm_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    // slot sequencer and result register
    owbm_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .timing (timing),
        .q_head (q_head),
        .q_pop  (q_pop),
        .res    (res)
    );

    // a transaction cannot both complete an operation and be turned away
    a_done_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.done_res && res.rejected))
        else $error("done and rejected in the same result");

    // completion always leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.done_res) |-> !res.busy_res)
        else $error("done reported while still busy");

    // the bus is never held low once idle
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.busy_res) |-> res.line_release)
        else $error("line pulled low while idle");

    // sequencer pops only a queued transaction
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

endmodule
